// File: hw/rtl/pcp_pkg.sv
`timescale 1ns / 1ps
// Shared widths, reset values, tables and types of the pose corner projector.
package pcp_pkg;

    localparam int DEF_CORDIC_ITERATIONS = 16;
    localparam int ATAN_LEN = 32;

    localparam int ANGLE_W  = 16;
    localparam int BAM_W    = 32;
    localparam int TRANS_W  = 32;
    localparam int FOCAL_W  = 24;
    localparam int CENTRE_W = 16;
    localparam int HALF_W   = 18;
    localparam int PIX_W    = 16;
    localparam int CORNERS  = 4;
    localparam int AXES     = 3;

    localparam int CRD_W  = 34;
    localparam int TRIG_W = 32;
    localparam int MAT_W  = 33;
    localparam int PROD_W = MAT_W + HALF_W + 1;
    localparam int ROT_W  = 54;
    localparam int CAM_W  = 34;
    localparam int NUM_W  = FOCAL_W + 1 + CAM_W;
    localparam int MAG_W  = NUM_W - 1;
    localparam int DEN_W  = CAM_W - 1;
    localparam int QUO_W  = MAG_W - DEN_W;
    localparam int QS_W   = QUO_W + 1;
    localparam int V_W    = QS_W + 2;

    localparam int FRAC_SHIFT = 30;
    localparam int HALF_SHIFT = 15;
    localparam int PIX_SHIFT  = 8;
    localparam int CENTRE_FRAC = 4;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [FOCAL_W-1:0]  FOCAL_RESET       = 24'd141891;
    localparam logic [CENTRE_W-1:0] CENTRE_COL_RESET  = 16'd5120;
    localparam logic [CENTRE_W-1:0] CENTRE_ROW_RESET  = 16'd3840;
    localparam logic [HALF_W-1:0]   HALF_ASPECT_RESET = 18'd32768;

    typedef enum logic [1:0] {
        REG_FOCAL       = 2'd0,
        REG_CENTRE_COL  = 2'd1,
        REG_CENTRE_ROW  = 2'd2,
        REG_HALF_ASPECT = 2'd3
    } reg_idx_t;

    localparam logic [31:0] ATAN_TABLE [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [TRIG_W-1:0] s;
        logic signed [TRIG_W-1:0] c;
    } trig_t;

    typedef struct packed {
        logic signed [TRANS_W-1:0] x;
        logic signed [TRANS_W-1:0] y;
        logic signed [TRANS_W-1:0] z;
    } trans_t;

    typedef struct packed {
        logic signed [CAM_W-1:0] x;
        logic signed [CAM_W-1:0] y;
        logic signed [CAM_W-1:0] z;
    } cam_t;

    typedef struct packed {
        logic signed [PIX_W-1:0] col;
        logic signed [PIX_W-1:0] row;
    } pixel_t;

    typedef struct packed {
        logic [FOCAL_W-1:0]  focal;
        logic [CENTRE_W-1:0] centre_col;
        logic [CENTRE_W-1:0] centre_row;
        logic [HALF_W-1:0]   half_aspect;
    } cfg_t;

endpackage

// File: hw/rtl/pcp_if.sv
`timescale 1ns / 1ps
// Pose input and corner output channel interfaces.
interface pcp_pose_if;
    logic                                valid;
    logic                                ready;
    logic signed [pcp_pkg::TRANS_W-1:0] trans_x;
    logic signed [pcp_pkg::TRANS_W-1:0] trans_y;
    logic signed [pcp_pkg::TRANS_W-1:0] trans_z;
    logic signed [pcp_pkg::ANGLE_W-1:0] yaw_angle;
    logic signed [pcp_pkg::ANGLE_W-1:0] pitch_angle;
    logic signed [pcp_pkg::ANGLE_W-1:0] roll_angle;

    modport source (
        output valid, trans_x, trans_y, trans_z, yaw_angle, pitch_angle, roll_angle,
        input  ready
    );
    modport sink (
        input  valid, trans_x, trans_y, trans_z, yaw_angle, pitch_angle, roll_angle,
        output ready
    );
endinterface

interface pcp_corner_if;
    logic                              valid;
    logic                              ready;
    logic signed [pcp_pkg::PIX_W-1:0] corner0_col;
    logic signed [pcp_pkg::PIX_W-1:0] corner0_row;
    logic signed [pcp_pkg::PIX_W-1:0] corner1_col;
    logic signed [pcp_pkg::PIX_W-1:0] corner1_row;
    logic signed [pcp_pkg::PIX_W-1:0] corner2_col;
    logic signed [pcp_pkg::PIX_W-1:0] corner2_row;
    logic signed [pcp_pkg::PIX_W-1:0] corner3_col;
    logic signed [pcp_pkg::PIX_W-1:0] corner3_row;
    logic                              behind_camera;

    modport source (
        output valid, corner0_col, corner0_row, corner1_col, corner1_row,
               corner2_col, corner2_row, corner3_col, corner3_row, behind_camera,
        input  ready
    );
    modport sink (
        input  valid, corner0_col, corner0_row, corner1_col, corner1_row,
               corner2_col, corner2_row, corner3_col, corner3_row, behind_camera,
        output ready
    );
endinterface

// File: hw/rtl/pcp_cordic.sv
`timescale 1ns / 1ps
// Pipelined CORDIC giving sine and cosine of three angles, one iteration per stage.
module pcp_cordic #(
    parameter int ITERATIONS = pcp_pkg::DEF_CORDIC_ITERATIONS,
    parameter int SIDE_W     = 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [pcp_pkg::ANGLE_W-1:0] angle [pcp_pkg::AXES],
    input  logic [SIDE_W-1:0]                   in_side,
    output logic                                out_valid,
    output pcp_pkg::trig_t                      out_trig [pcp_pkg::AXES],
    output logic [SIDE_W-1:0]                   out_side
);

    localparam int W = pcp_pkg::CRD_W;
    localparam int L = pcp_pkg::AXES;
    localparam int PAD = pcp_pkg::BAM_W - pcp_pkg::ANGLE_W;

    logic signed [W-1:0] x_reg [ITERATIONS+1][L];
    logic signed [W-1:0] y_reg [ITERATIONS+1][L];
    logic signed [W-1:0] z_reg [ITERATIONS+1][L];
    logic                flip_reg [ITERATIONS+1][L];
    logic [SIDE_W-1:0]   side_reg [ITERATIONS+1];
    logic [ITERATIONS:0] valid_reg;

    logic                out_valid_reg;
    pcp_pkg::trig_t      trig_reg [L];
    logic [SIDE_W-1:0]   out_side_reg;

    logic [pcp_pkg::BAM_W-1:0] bam [L];
    logic                      fold [L];
    logic signed [W-1:0]       z_init [L];

    // Move angles in the left half-plane by pi; negate the results at the end.
    always_comb
    begin
        for (int l = 0; l < L; l++)
        begin
            bam[l]    = {angle[l], {PAD{1'b0}}};
            fold[l]   = bam[l][pcp_pkg::BAM_W-1] ^ bam[l][pcp_pkg::BAM_W-2];
            z_init[l] = W'($signed({bam[l][pcp_pkg::BAM_W-1] ^ fold[l],
                                    bam[l][pcp_pkg::BAM_W-2:0]}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg     <= {valid_reg[ITERATIONS-1:0], in_valid};
            out_valid_reg <= valid_reg[ITERATIONS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < L; l++)
            begin
                x_reg[0][l]    <= pcp_pkg::CORDIC_GAIN;
                y_reg[0][l]    <= '0;
                z_reg[0][l]    <= z_init[l];
                flip_reg[0][l] <= fold[l];
            end
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 0; k < ITERATIONS; k++)
    begin : g_iter
        localparam logic signed [W-1:0] ATAN = W'(pcp_pkg::ATAN_TABLE[k]);

        logic signed [W-1:0] x_next [L];
        logic signed [W-1:0] y_next [L];
        logic signed [W-1:0] z_next [L];

        always_comb
        begin
            for (int l = 0; l < L; l++)
            begin
                if (!z_reg[k][l][W-1])
                begin
                    x_next[l] = x_reg[k][l] - (y_reg[k][l] >>> k);
                    y_next[l] = y_reg[k][l] + (x_reg[k][l] >>> k);
                    z_next[l] = z_reg[k][l] - ATAN;
                end
                else
                begin
                    x_next[l] = x_reg[k][l] + (y_reg[k][l] >>> k);
                    y_next[l] = y_reg[k][l] - (x_reg[k][l] >>> k);
                    z_next[l] = z_reg[k][l] + ATAN;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < L; l++)
                begin
                    x_reg[k+1][l]    <= x_next[l];
                    y_reg[k+1][l]    <= y_next[l];
                    z_reg[k+1][l]    <= z_next[l];
                    flip_reg[k+1][l] <= flip_reg[k][l];
                end
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < L; l++)
            begin
                if (flip_reg[ITERATIONS][l])
                begin
                    trig_reg[l].c <= pcp_pkg::TRIG_W'(-x_reg[ITERATIONS][l]);
                    trig_reg[l].s <= pcp_pkg::TRIG_W'(-y_reg[ITERATIONS][l]);
                end
                else
                begin
                    trig_reg[l].c <= pcp_pkg::TRIG_W'(x_reg[ITERATIONS][l]);
                    trig_reg[l].s <= pcp_pkg::TRIG_W'(y_reg[ITERATIONS][l]);
                end
            end
            out_side_reg <= side_reg[ITERATIONS];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_trig  = trig_reg;
    assign out_side  = out_side_reg;

endmodule

// File: hw/rtl/pcp_rotmat.sv
`timescale 1ns / 1ps
// Rotation matrix build and corner transform into camera coordinates.
module pcp_rotmat (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  pcp_pkg::trig_t                     trig [pcp_pkg::AXES],
    input  pcp_pkg::trans_t                    in_trans,
    input  logic [pcp_pkg::HALF_W-1:0]         half_aspect,
    output logic                               out_valid,
    output pcp_pkg::cam_t                      cam [pcp_pkg::CORNERS]
);

    localparam int TW = pcp_pkg::TRIG_W;
    localparam int MW = pcp_pkg::MAT_W;
    localparam int RW = pcp_pkg::ROT_W;
    localparam int CW = pcp_pkg::CAM_W;
    localparam int NC = pcp_pkg::CORNERS;
    localparam int NA = pcp_pkg::AXES;
    localparam int DEPTH = 6;
    localparam int TRANS_W_L = pcp_pkg::TRANS_W;
    localparam logic signed [RW-1:0] ROUND30 = RW'(64'sd1 <<< (pcp_pkg::FRAC_SHIFT - 1));

    function automatic logic signed [TW-1:0] mul30(
        input logic signed [TW-1:0] a,
        input logic signed [TW-1:0] b
    );
        logic signed [2*TW-1:0] p;
        p = a * b + ((2*TW)'(64'sd1) <<< (pcp_pkg::FRAC_SHIFT - 1));
        return p[pcp_pkg::FRAC_SHIFT +: TW];
    endfunction

    logic [DEPTH-1:0] valid_reg;

    // stage 1
    logic signed [TW-1:0] sbsc_reg, cacb1_reg, sacc1_reg, sacb1_reg, cacc1_reg, cbsc1_reg;
    logic signed [TW-1:0] ca1_reg, sa1_reg, sb1_reg;
    pcp_pkg::trans_t      t1_reg;
    // stage 2
    logic signed [TW-1:0] casbsc_reg, sasbsc_reg;
    logic signed [TW-1:0] cacb2_reg, sacc2_reg, sacb2_reg, cacc2_reg, cbsc2_reg, sb2_reg;
    pcp_pkg::trans_t      t2_reg;
    // stage 3
    logic signed [MW-1:0] r0_reg [NA];
    logic signed [MW-1:0] r1_reg [NA];
    pcp_pkg::trans_t      t3_reg;
    // stage 4
    logic signed [MW-1:0]              r0s_reg [NA];
    logic signed [pcp_pkg::PROD_W-1:0] prod_reg [NA];
    pcp_pkg::trans_t                   t4_reg;
    // stage 5
    logic signed [RW-1:0] rot_reg [NC][NA];
    pcp_pkg::trans_t      t5_reg;
    // stage 6
    pcp_pkg::cam_t        cam_reg [NC];

    logic signed [pcp_pkg::HALF_W:0] h_s;
    logic signed [RW-1:0]            rot_next [NC][NA];
    logic signed [RW-1:0]            qx, py_term;
    logic signed [TRANS_W_L-1:0]     t_axis [NA];

    assign h_s = $signed({1'b0, half_aspect});

    always_comb
    begin
        t_axis[0] = t5_reg.x;
        t_axis[1] = t5_reg.y;
        t_axis[2] = t5_reg.z;
    end

    // Corner k: x is -0.5 for the left corners, y is -h for the top corners.
    always_comb
    begin
        qx      = '0;
        py_term = '0;
        for (int k = 0; k < NC; k++)
        begin
            for (int j = 0; j < NA; j++)
            begin
                qx      = RW'(r0s_reg[j]) <<< pcp_pkg::HALF_SHIFT;
                py_term = RW'(prod_reg[j]);
                if (k == 0 || k == 3)
                begin
                    qx = -qx;
                end
                if (k < 2)
                begin
                    py_term = -py_term;
                end
                rot_next[k][j] = qx + py_term + ROUND30;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sbsc_reg  <= mul30(trig[1].s, trig[2].s);
            cacb1_reg <= mul30(trig[0].c, trig[1].c);
            sacc1_reg <= mul30(trig[0].s, trig[2].c);
            sacb1_reg <= mul30(trig[0].s, trig[1].c);
            cacc1_reg <= mul30(trig[0].c, trig[2].c);
            cbsc1_reg <= mul30(trig[1].c, trig[2].s);
            ca1_reg   <= trig[0].c;
            sa1_reg   <= trig[0].s;
            sb1_reg   <= trig[1].s;
            t1_reg    <= in_trans;

            casbsc_reg <= mul30(ca1_reg, sbsc_reg);
            sasbsc_reg <= mul30(sa1_reg, sbsc_reg);
            cacb2_reg  <= cacb1_reg;
            sacc2_reg  <= sacc1_reg;
            sacb2_reg  <= sacb1_reg;
            cacc2_reg  <= cacc1_reg;
            cbsc2_reg  <= cbsc1_reg;
            sb2_reg    <= sb1_reg;
            t2_reg     <= t1_reg;

            r0_reg[0] <= MW'(cacb2_reg);
            r1_reg[0] <= MW'(casbsc_reg) - MW'(sacc2_reg);
            r0_reg[1] <= MW'(sacb2_reg);
            r1_reg[1] <= MW'(sasbsc_reg) + MW'(cacc2_reg);
            r0_reg[2] <= -MW'(sb2_reg);
            r1_reg[2] <= MW'(cbsc2_reg);
            t3_reg    <= t2_reg;

            for (int j = 0; j < NA; j++)
            begin
                r0s_reg[j]  <= r0_reg[j];
                prod_reg[j] <= r1_reg[j] * h_s;
            end
            t4_reg <= t3_reg;

            rot_reg <= rot_next;
            t5_reg  <= t4_reg;

            for (int k = 0; k < NC; k++)
            begin
                cam_reg[k].x <= CW'(rot_reg[k][0] >>> pcp_pkg::FRAC_SHIFT) + CW'(t_axis[0]);
                cam_reg[k].y <= CW'(rot_reg[k][1] >>> pcp_pkg::FRAC_SHIFT) + CW'(t_axis[1]);
                cam_reg[k].z <= CW'(rot_reg[k][2] >>> pcp_pkg::FRAC_SHIFT) + CW'(t_axis[2]);
            end
        end
    end

    assign out_valid = valid_reg[DEPTH-1];
    assign cam       = cam_reg;

endmodule

// File: hw/rtl/pcp_project.sv
`timescale 1ns / 1ps
// Pinhole projection: focal multiply, bit-per-stage divide, rounding and saturation.
module pcp_project (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  pcp_pkg::cam_t        cam [pcp_pkg::CORNERS],
    input  pcp_pkg::cfg_t        cfg,
    output logic                 out_valid,
    output pcp_pkg::pixel_t      pix [pcp_pkg::CORNERS],
    output logic                 out_behind
);

    localparam int NC    = pcp_pkg::CORNERS;
    localparam int LANES = 2 * NC;
    localparam int NW    = pcp_pkg::NUM_W;
    localparam int MG    = pcp_pkg::MAG_W;
    localparam int DW    = pcp_pkg::DEN_W;
    localparam int QW    = pcp_pkg::QUO_W;
    localparam int VW    = pcp_pkg::V_W;
    localparam int PW    = pcp_pkg::PIX_W;
    localparam int SW    = VW - pcp_pkg::PIX_SHIFT;
    localparam int DEPTH = QW + 5;

    localparam logic signed [VW-1:0] ROUND_PIX = VW'(1 << (pcp_pkg::PIX_SHIFT - 1));
    localparam logic signed [VW-1:0] TRUNC_ADJ = VW'((1 << pcp_pkg::PIX_SHIFT) - 1);
    localparam logic signed [SW-1:0] PIX_MAX = SW'((1 << (PW - 1)) - 1);
    localparam logic signed [SW-1:0] PIX_MIN = -SW'(1 << (PW - 1));

    logic [DEPTH-1:0] valid_reg;

    // P1
    logic signed [NW-1:0] num1_reg [LANES];
    logic [DW-1:0]        den1_reg [NC];
    logic                 beh1_reg [NC];
    // P2
    logic [MG-1:0]        mag2_reg [LANES];
    logic                 neg2_reg [LANES];
    logic [DW-1:0]        den2_reg [NC];
    logic                 beh2_reg [NC];
    // divider, index 0 is the setup stage
    logic [MG-1:0]        rem_reg [QW+1][LANES];
    logic [QW-1:0]        quo_reg [QW+1][LANES];
    logic                 ovf_reg [QW+1][LANES];
    logic                 neg_reg [QW+1][LANES];
    logic [DW-1:0]        den_reg [QW+1][NC];
    logic                 beh_reg [QW+1][NC];
    // F1
    logic signed [VW-1:0] v_reg [LANES];
    logic                 behf_reg [NC];
    // F2
    pcp_pkg::pixel_t      pix_reg [NC];
    logic                 behind_reg;

    logic signed [pcp_pkg::FOCAL_W:0] focal_s;
    logic signed [NW-1:0]             num_next [LANES];
    logic [DW-1:0]                    den_next [NC];
    logic                             beh_next [NC];

    assign focal_s = $signed({1'b0, cfg.focal});

    always_comb
    begin
        for (int k = 0; k < NC; k++)
        begin
            beh_next[k] = cam[k].z[pcp_pkg::CAM_W-1] || (cam[k].z == '0);
            den_next[k] = beh_next[k] ? DW'(1) : cam[k].z[DW-1:0];
            num_next[2*k]     = focal_s * cam[k].x;
            num_next[2*k + 1] = focal_s * cam[k].y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num1_reg <= num_next;
            den1_reg <= den_next;
            beh1_reg <= beh_next;

            for (int l = 0; l < LANES; l++)
            begin
                neg2_reg[l] <= num1_reg[l][NW-1];
                mag2_reg[l] <= num1_reg[l][NW-1] ? MG'(-num1_reg[l]) : MG'(num1_reg[l]);
            end
            den2_reg <= den1_reg;
            beh2_reg <= beh1_reg;

            // Quotients too large for the pixel range saturate anyway: clamp them.
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[0][l] <= mag2_reg[l];
                ovf_reg[0][l] <= mag2_reg[l] >= {den2_reg[l >> 1], {QW{1'b0}}};
                quo_reg[0][l] <= (mag2_reg[l] >= {den2_reg[l >> 1], {QW{1'b0}}}) ? '1 : '0;
                neg_reg[0][l] <= neg2_reg[l];
            end
            den_reg[0] <= den2_reg;
            beh_reg[0] <= beh2_reg;
        end
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_div
        localparam int B = QW - 1 - s;

        logic [MG-1:0] rem_next [LANES];
        logic [QW-1:0] quo_next [LANES];
        logic [MG-1:0] trial    [LANES];

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                trial[l]    = MG'(den_reg[s][l >> 1]) << B;
                rem_next[l] = rem_reg[s][l];
                quo_next[l] = quo_reg[s][l];
                if (!ovf_reg[s][l] && (rem_reg[s][l] >= trial[l]))
                begin
                    rem_next[l]    = rem_reg[s][l] - trial[l];
                    quo_next[l][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= rem_next;
                quo_reg[s+1] <= quo_next;
                ovf_reg[s+1] <= ovf_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                den_reg[s+1] <= den_reg[s];
                beh_reg[s+1] <= beh_reg[s];
            end
        end
    end

    logic signed [pcp_pkg::QS_W-1:0] qs [LANES];
    logic signed [VW-1:0]            centre16 [LANES];
    logic signed [VW-1:0]            adj [LANES];
    logic signed [SW-1:0]            shifted [LANES];
    logic signed [PW-1:0]            sat [LANES];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            qs[l] = neg_reg[QW][l] ? -$signed({1'b0, quo_reg[QW][l]})
                                   :  $signed({1'b0, quo_reg[QW][l]});
            centre16[l] = l[0] ? VW'({cfg.centre_row, {pcp_pkg::CENTRE_FRAC{1'b0}}})
                               : VW'({cfg.centre_col, {pcp_pkg::CENTRE_FRAC{1'b0}}});
            // Truncate toward zero: bias negative values before the shift.
            adj[l]     = v_reg[l] + (v_reg[l][VW-1] ? TRUNC_ADJ : '0);
            shifted[l] = SW'(adj[l] >>> pcp_pkg::PIX_SHIFT);
            if (shifted[l] > PIX_MAX)
            begin
                sat[l] = PW'(PIX_MAX);
            end
            else if (shifted[l] < PIX_MIN)
            begin
                sat[l] = PW'(PIX_MIN);
            end
            else
            begin
                sat[l] = PW'(shifted[l]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                v_reg[l] <= VW'(qs[l]) + centre16[l] + ROUND_PIX;
            end
            behf_reg <= beh_reg[QW];

            for (int k = 0; k < NC; k++)
            begin
                pix_reg[k].col <= behf_reg[k] ? '0 : sat[2*k];
                pix_reg[k].row <= behf_reg[k] ? '0 : sat[2*k + 1];
            end
            behind_reg <= behf_reg[0] | behf_reg[1] | behf_reg[2] | behf_reg[3];
        end
    end

    assign out_valid  = valid_reg[DEPTH-1];
    assign pix        = pix_reg;
    assign out_behind = behind_reg;

endmodule

// File: hw/rtl/pose_corner_projection.sv
`timescale 1ns / 1ps
// A result passes through CORDIC stages, six matrix stages and 30 projection stages.
// Throughput: one pose per cycle unless a result is held at the output; the quotient
// pipeline retires one bit per stage.
// The whole pipeline holds while a result waits at the output and is not taken.
// Reset clears all valid bits and loads the default camera configuration.
module pose_corner_projection #(
    parameter int CORDIC_ITERATIONS = pcp_pkg::DEF_CORDIC_ITERATIONS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    pcp_pose_if.sink                    pose,
    pcp_corner_if.source                corners,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pcp_pkg::APB_AW-1:0]  paddr,
    input  logic [pcp_pkg::APB_DW-1:0]  pwdata,
    output logic [pcp_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    localparam int SIDE_W = $bits(pcp_pkg::trans_t);

    pcp_pkg::cfg_t    cfg_reg;
    pcp_pkg::reg_idx_t reg_idx;
    logic             en;

    logic signed [pcp_pkg::ANGLE_W-1:0] angle [pcp_pkg::AXES];
    pcp_pkg::trans_t  trans_in;
    pcp_pkg::trans_t  trans_crd;
    logic [SIDE_W-1:0] side_out;
    pcp_pkg::trig_t   trig [pcp_pkg::AXES];
    logic             crd_valid;
    logic             rot_valid;
    pcp_pkg::cam_t    cam [pcp_pkg::CORNERS];
    logic             prj_valid;
    pcp_pkg::pixel_t  pix [pcp_pkg::CORNERS];
    logic             behind;

    // Advance everything unless a finished transaction is held at the output.
    assign en         = !corners.valid || corners.ready;
    assign pose.ready = en;

    assign angle[0] = pose.yaw_angle;
    assign angle[1] = pose.pitch_angle;
    assign angle[2] = pose.roll_angle;
    assign trans_in = '{x: pose.trans_x, y: pose.trans_y, z: pose.trans_z};
    assign trans_crd = pcp_pkg::trans_t'(side_out);

    assign reg_idx = pcp_pkg::reg_idx_t'(paddr[pcp_pkg::APB_AW-1:2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal       <= pcp_pkg::FOCAL_RESET;
            cfg_reg.centre_col  <= pcp_pkg::CENTRE_COL_RESET;
            cfg_reg.centre_row  <= pcp_pkg::CENTRE_ROW_RESET;
            cfg_reg.half_aspect <= pcp_pkg::HALF_ASPECT_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                pcp_pkg::REG_FOCAL:       cfg_reg.focal       <= pwdata[pcp_pkg::FOCAL_W-1:0];
                pcp_pkg::REG_CENTRE_COL:  cfg_reg.centre_col  <= pwdata[pcp_pkg::CENTRE_W-1:0];
                pcp_pkg::REG_CENTRE_ROW:  cfg_reg.centre_row  <= pwdata[pcp_pkg::CENTRE_W-1:0];
                pcp_pkg::REG_HALF_ASPECT: cfg_reg.half_aspect <= pwdata[pcp_pkg::HALF_W-1:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            pcp_pkg::REG_FOCAL:       prdata = pcp_pkg::APB_DW'(cfg_reg.focal);
            pcp_pkg::REG_CENTRE_COL:  prdata = pcp_pkg::APB_DW'(cfg_reg.centre_col);
            pcp_pkg::REG_CENTRE_ROW:  prdata = pcp_pkg::APB_DW'(cfg_reg.centre_row);
            pcp_pkg::REG_HALF_ASPECT: prdata = pcp_pkg::APB_DW'(cfg_reg.half_aspect);
            default:                  prdata = '0;
        endcase
    end

    pcp_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS),
        .SIDE_W     (SIDE_W)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pose.valid),
        .angle     (angle),
        .in_side   (trans_in),
        .out_valid (crd_valid),
        .out_trig  (trig),
        .out_side  (side_out)
    );

    pcp_rotmat u_rotmat (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (crd_valid),
        .trig        (trig),
        .in_trans    (trans_crd),
        .half_aspect (cfg_reg.half_aspect),
        .out_valid   (rot_valid),
        .cam         (cam)
    );

    pcp_project u_project (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (rot_valid),
        .cam        (cam),
        .cfg        (cfg_reg),
        .out_valid  (prj_valid),
        .pix        (pix),
        .out_behind (behind)
    );

    assign corners.valid         = prj_valid;
    assign corners.corner0_col   = pix[0].col;
    assign corners.corner0_row   = pix[0].row;
    assign corners.corner1_col   = pix[1].col;
    assign corners.corner1_row   = pix[1].row;
    assign corners.corner2_col   = pix[2].col;
    assign corners.corner2_row   = pix[2].row;
    assign corners.corner3_col   = pix[3].col;
    assign corners.corner3_row   = pix[3].row;
    assign corners.behind_camera = behind;

`ifndef SYNTH
    a_hold_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (corners.valid && !corners.ready) |-> !pose.ready)
        else $error("input taken while output transaction held");

    a_ready_low_only_on_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !pose.ready |-> corners.valid)
        else $error("input stalled with empty output");

    a_behind_zeroes_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (corners.valid && corners.behind_camera) |->
            ((corners.corner0_col == '0 && corners.corner0_row == '0) ||
             (corners.corner1_col == '0 && corners.corner1_row == '0) ||
             (corners.corner2_col == '0 && corners.corner2_row == '0) ||
             (corners.corner3_col == '0 && corners.corner3_row == '0)))
        else $error("behind flag set with no zeroed corner");
`endif

endmodule

// File: dv/pose_corner_projection_tb.sv
`timescale 1ns / 1ps
// Pose corner projector self-checking bench: directed and random poses vs a bit-exact model.
module pose_corner_projection_tb;

    localparam int LATENCY     = pcp_pkg::DEF_CORDIC_ITERATIONS + 38;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_POSES = 1650;

    typedef struct {
        logic signed [pcp_pkg::TRANS_W-1:0] tx, ty, tz;
        logic signed [pcp_pkg::ANGLE_W-1:0] yaw, pitch, roll;
    } pose_item_t;

    typedef struct {
        logic signed [pcp_pkg::PIX_W-1:0] col [pcp_pkg::CORNERS];
        logic signed [pcp_pkg::PIX_W-1:0] row [pcp_pkg::CORNERS];
        logic                             behind;
    } corner_set_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [pcp_pkg::APB_AW-1:0] paddr;
    logic [pcp_pkg::APB_DW-1:0] pwdata;
    logic [pcp_pkg::APB_DW-1:0] prdata;
    logic pready;

    pcp_pose_if   pose_ch ();
    pcp_corner_if corner_ch ();

    pose_corner_projection DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .pose    (pose_ch),
        .corners (corner_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    pcp_pkg::cfg_t cam_cfg;
    pose_item_t    pending_poses [$];
    corner_set_t   expected_corners [$];
    int            errors = 0;
    int            cycles = 0;
    int            sender_idle_pct = 0;
    int            stall_pct = 0;
    logic          hold_poses = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint mul_q30(longint a, longint b);
        return (a * b + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function automatic void cordic_sin_cos(logic [pcp_pkg::ANGLE_W-1:0] ang, output longint s,
                                           output longint c);
        logic [pcp_pkg::BAM_W-1:0] u;
        logic                      flip;
        longint                    x, y, z, dx, dy;
        u = {ang, 16'h0000};
        flip = 1'b0;
        x = pcp_pkg::CORDIC_GAIN;
        y = 0;
        if (u >= 32'h40000000 && u < 32'hC0000000)
        begin
            u = u + 32'h80000000;
            flip = 1'b1;
        end
        z = longint'($signed(u));
        for (int i = 0; i < pcp_pkg::DEF_CORDIC_ITERATIONS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - longint'(pcp_pkg::ATAN_TABLE[i]);
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + longint'(pcp_pkg::ATAN_TABLE[i]);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic signed [pcp_pkg::PIX_W-1:0] pixel_of(longint num, longint depth,
                                                                  longint centre);
        longint q8, p;
        q8 = num / depth + centre * 16;
        p = (q8 + 128) / 256;
        if (p > 32767) p = 32767;
        if (p < -32768) p = -32768;
        return p[pcp_pkg::PIX_W-1:0];
    endfunction

    function automatic corner_set_t project_pose(pose_item_t p);
        corner_set_t res;
        longint      t [pcp_pkg::AXES];
        longint      r [pcp_pkg::AXES][2];
        longint      cam [pcp_pkg::AXES];
        longint      sa, ca, sb, cb, sc, cc, sbsc, px, py, h, rot;
        t[0] = p.tx; t[1] = p.ty; t[2] = p.tz;
        h = cam_cfg.half_aspect;
        cordic_sin_cos(p.yaw, sa, ca);
        cordic_sin_cos(p.pitch, sb, cb);
        cordic_sin_cos(p.roll, sc, cc);
        sbsc = mul_q30(sb, sc);
        r[0][0] = mul_q30(ca, cb);
        r[0][1] = mul_q30(ca, sbsc) - mul_q30(sa, cc);
        r[1][0] = mul_q30(sa, cb);
        r[1][1] = mul_q30(sa, sbsc) + mul_q30(ca, cc);
        r[2][0] = -sb;
        r[2][1] = mul_q30(cb, sc);
        res.behind = 1'b0;
        for (int k = 0; k < pcp_pkg::CORNERS; k++)
        begin
            px = (k == 0 || k == 3) ? -32768 : 32768;
            py = (k < 2) ? -h : h;
            for (int j = 0; j < pcp_pkg::AXES; j++)
            begin
                rot = r[j][0] * px + r[j][1] * py;
                cam[j] = ((rot + (64'sd1 <<< 29)) >>> 30) + t[j];
            end
            if (cam[2] <= 0)
            begin
                res.behind = 1'b1;
                res.col[k] = '0;
                res.row[k] = '0;
            end
            else
            begin
                res.col[k] = pixel_of(longint'(cam_cfg.focal) * cam[0], cam[2],
                                      longint'(cam_cfg.centre_col));
                res.row[k] = pixel_of(longint'(cam_cfg.focal) * cam[1], cam[2],
                                      longint'(cam_cfg.centre_row));
            end
        end
        return res;
    endfunction

    // Pose driver: advance on acceptance, idle at random.
    always @(posedge clk)
    begin
        if (!rst_n)
            pose_ch.valid <= 1'b0;
        else if (!pose_ch.valid || pose_ch.ready)
        begin
            if (pending_poses.size() > 0 && !hold_poses
                && $urandom_range(99) >= sender_idle_pct)
            begin
                pose_item_t p;
                p = pending_poses.pop_front();
                pose_ch.trans_x     <= p.tx;
                pose_ch.trans_y     <= p.ty;
                pose_ch.trans_z     <= p.tz;
                pose_ch.yaw_angle   <= p.yaw;
                pose_ch.pitch_angle <= p.pitch;
                pose_ch.roll_angle  <= p.roll;
                pose_ch.valid       <= 1'b1;
            end
            else
                pose_ch.valid <= 1'b0;
        end
    end

    always @(posedge clk)
        corner_ch.ready <= rst_n && ($urandom_range(99) >= stall_pct);

    // Monitor: predict on accepted poses, check accepted corner sets.
    always @(posedge clk)
    begin
        if (rst_n && pose_ch.valid && pose_ch.ready)
        begin
            pose_item_t p;
            p.tx = pose_ch.trans_x; p.ty = pose_ch.trans_y; p.tz = pose_ch.trans_z;
            p.yaw = pose_ch.yaw_angle; p.pitch = pose_ch.pitch_angle;
            p.roll = pose_ch.roll_angle;
            expected_corners = {expected_corners, project_pose(p)};
        end
        if (rst_n && corner_ch.valid && corner_ch.ready)
        begin
            corner_set_t e;
            logic signed [pcp_pkg::PIX_W-1:0] ac [pcp_pkg::CORNERS];
            logic signed [pcp_pkg::PIX_W-1:0] ar [pcp_pkg::CORNERS];
            if (expected_corners.size() == 0)
            begin
                $error("corner set with no pose outstanding");
                errors++;
            end
            else
            begin
                e = expected_corners.pop_front();
                ac = '{corner_ch.corner0_col, corner_ch.corner1_col,
                       corner_ch.corner2_col, corner_ch.corner3_col};
                ar = '{corner_ch.corner0_row, corner_ch.corner1_row,
                       corner_ch.corner2_row, corner_ch.corner3_row};
                for (int k = 0; k < pcp_pkg::CORNERS; k++)
                begin
                    if (ac[k] !== e.col[k])
                    begin
                        $error("corner%0d_col expected %0d actual %0d", k, e.col[k], ac[k]);
                        errors++;
                    end
                    if (ar[k] !== e.row[k])
                    begin
                        $error("corner%0d_row expected %0d actual %0d", k, e.row[k], ar[k]);
                        errors++;
                    end
                end
                if (corner_ch.behind_camera !== e.behind)
                begin
                    $error("behind_camera expected %0b actual %0b", e.behind,
                           corner_ch.behind_camera);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(pcp_pkg::reg_idx_t idx, logic [pcp_pkg::APB_DW-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= pcp_pkg::APB_AW'(idx) << 2;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            pcp_pkg::REG_FOCAL:       cam_cfg.focal       = val[pcp_pkg::FOCAL_W-1:0];
            pcp_pkg::REG_CENTRE_COL:  cam_cfg.centre_col  = val[pcp_pkg::CENTRE_W-1:0];
            pcp_pkg::REG_CENTRE_ROW:  cam_cfg.centre_row  = val[pcp_pkg::CENTRE_W-1:0];
            pcp_pkg::REG_HALF_ASPECT: cam_cfg.half_aspect = val[pcp_pkg::HALF_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_poses.size() > 0 || pose_ch.valid || expected_corners.size() > 0)
            @(posedge clk);
    endtask

    task automatic add_pose(int tx, int ty, int tz, int yaw, int pitch, int roll);
        pose_item_t p;
        p.tx = tx; p.ty = ty; p.tz = tz;
        p.yaw   = yaw[pcp_pkg::ANGLE_W-1:0];
        p.pitch = pitch[pcp_pkg::ANGLE_W-1:0];
        p.roll  = roll[pcp_pkg::ANGLE_W-1:0];
        pending_poses = {pending_poses, p};
    endtask

    task automatic add_random_poses(int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 75)
                add_pose($signed($urandom_range(32'h80000)) - 32'sh40000,
                         $signed($urandom_range(32'h80000)) - 32'sh40000,
                         $urandom_range(32'h8000, 32'h200000),
                         $urandom, $urandom, $urandom);
            else
                add_pose($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cam_cfg.focal       = pcp_pkg::FOCAL_RESET;
        cam_cfg.centre_col  = pcp_pkg::CENTRE_COL_RESET;
        cam_cfg.centre_row  = pcp_pkg::CENTRE_ROW_RESET;
        cam_cfg.half_aspect = pcp_pkg::HALF_ASPECT_RESET;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: axis angles, quadrant edges, extreme and non-positive depths.
        add_pose(0, 0, 32'sh50000, 0, 0, 0);
        add_pose(0, 0, 32'sh50000, 16384, 0, 0);
        add_pose(0, 0, 32'sh50000, -16384, 0, 0);
        add_pose(0, 0, 32'sh50000, 32767, 32767, 32767);
        add_pose(0, 0, 32'sh50000, -32768, -32768, -32768);
        add_pose(0, 0, 32'sh50000, 16383, -16385, 8192);
        add_pose(0, 0, 32'sh50000, 0, 16384, 0);
        add_pose(0, 0, 32'sh50000, 0, 0, 16384);
        add_pose(32'sh10000, -32'sh8000, 32'sh30000, 1000, -2000, 3000);
        add_pose(0, 0, 0, 0, 0, 0);
        add_pose(0, 0, -32'sh10000, 0, 0, 0);
        add_pose(0, 0, 32'sh4000, 0, 16384, 0);
        add_pose(0, 0, 1, 0, 0, 0);
        add_pose(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32767, 32767, 32767);
        add_pose(32'sh80000000, 32'sh80000000, 32'sh80000000, -32768, -32768, -32768);
        add_pose(32'sh7FFFFFFF, 32'sh80000000, 1, 0, 0, 0);
        add_pose(32'sh80000000, 32'sh7FFFFFFF, 32'sh100, 0, 0, 0);
        add_pose(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0);
        add_pose(-1, -1, 32'sh7FFFFFFF, 0, 0, 0);
        add_random_poses(RANDOM_POSES / 4);
        wait_drained();

        for (int ph = 1; ph < 4; ph++)
        begin
            repeat (LATENCY + 10) @(posedge clk);
            case (ph)
                1:
                begin
                    sender_idle_pct = 57; stall_pct = 0;
                    write_reg(pcp_pkg::REG_FOCAL, 32'hFFFFFF);
                    write_reg(pcp_pkg::REG_CENTRE_COL, 32'hFFFF);
                    write_reg(pcp_pkg::REG_CENTRE_ROW, 32'hFFFF);
                    write_reg(pcp_pkg::REG_HALF_ASPECT, 32'h3FFFF);
                end
                2:
                begin
                    sender_idle_pct = 0; stall_pct = 57;
                    write_reg(pcp_pkg::REG_FOCAL, 0);
                    write_reg(pcp_pkg::REG_CENTRE_COL, 0);
                    write_reg(pcp_pkg::REG_CENTRE_ROW, 0);
                    write_reg(pcp_pkg::REG_HALF_ASPECT, 0);
                end
                default:
                begin
                    sender_idle_pct = 9; stall_pct = 9;
                    write_reg(pcp_pkg::REG_FOCAL, $urandom);
                    write_reg(pcp_pkg::REG_CENTRE_COL, $urandom);
                    write_reg(pcp_pkg::REG_CENTRE_ROW, $urandom);
                    write_reg(pcp_pkg::REG_HALF_ASPECT, $urandom);
                end
            endcase
            add_random_poses(RANDOM_POSES / 4);
            if (ph == 1)
            begin
                // Hold the sender mid-phase until the pipeline has emptied.
                while (pending_poses.size() > RANDOM_POSES / 8)
                    @(posedge clk);
                hold_poses = 1'b1;
                while (pose_ch.valid || expected_corners.size() > 0)
                    @(posedge clk);
                hold_poses = 1'b0;
            end
            wait_drained();
        end

        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

// File: pose_corner_projection.f
hw/rtl/pcp_pkg.sv
hw/rtl/pcp_if.sv
hw/rtl/pcp_cordic.sv
hw/rtl/pcp_rotmat.sv
hw/rtl/pcp_project.sv
hw/rtl/pose_corner_projection.sv
dv/pose_corner_projection_tb.sv
